### design/cagen_pkg.sv
`timescale 1ns / 1ps

package cagen_pkg;

    // grid limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int POS_W     = 6;
    localparam int CNT_W     = 3;

    // reset values and lower limits of the size registers
    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd40;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd60;
    localparam logic [CFG_W-1:0] ROWS_MIN   = 7'd1;
    localparam logic [CFG_W-1:0] COLS_MIN   = 7'd2;

    // neighbor count thresholds of the rule
    localparam logic [CNT_W-1:0] FULL_CNT   = 3'd4;
    localparam logic [CNT_W-1:0] TRIPLE_CNT = 3'd3;
    localparam logic [CNT_W-1:0] PAIR_CNT   = 3'd2;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE,
        CFG_COLS_IN_USE
    } cagen_cfg_idx_t;

    typedef struct packed {
        logic mode;
        logic cell_value;
    } cagen_in_t;

    typedef struct packed {
        logic             next_value;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
        logic             last_of_run;
        logic             frame_done;
    } cagen_out_t;

    // neighborhood of the current item, as seen by the stencil
    typedef struct packed {
        logic [5:0]       window;
        logic             nt;
        logic             nm;
        logic             nb;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_end;
        logic             flush_row;
    } cagen_nbhd_t;

    // up to two results for one item, first in order before second
    typedef struct packed {
        logic       first_vld;
        logic       second_vld;
        cagen_out_t first;
        cagen_out_t second;
    } cagen_pair_t;

endpackage

### design/cellular_automaton_generation_step.sv
`timescale 1ns / 1ps
// output: a result enters the result queue when the item that releases it is accepted
// throughput: one item per cycle while the result queue has room for a pair; outside
//   the first row a row-end item yields two results and a first-column item none, so
//   a row of cols_in_use items yields as many results via the four-deep result queue
// reset: synchronous active-low aresetn clears positions, window, line valid bits and
//   the result queue; rows_in_use returns to 40 and cols_in_use to 60
module cellular_automaton_generation_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cagen_pkg::cagen_in_t            s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cagen_pkg::cagen_out_t           m_data,
    input  logic                            cfg_we,
    input  logic [cagen_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cagen_pkg::CFG_W-1:0]     cfg_data
);
    import cagen_pkg::*;

    // size registers
    logic [CFG_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CFG_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0] rows_use, cols_use;

    // raster position and 3x3 window (two previous columns)
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [5:0]       window_reg, window_next;
    logic [5:0]       window_eff;

    logic             fire;
    logic             row_end, flush_row;
    logic [CFG_W-1:0] col_plus;
    logic             nt, nm, nb;
    logic             mid_rd, up_rd;
    logic [COL_W-1:0] rd_addr;
    logic             has_room;
    logic             push_first, push_second;
    cagen_out_t       first_data;
    cagen_nbhd_t      nbhd;
    cagen_pair_t      pair;

    // config writes; the user must keep the block idle for them, it does not enforce this
    always_comb begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ROWS_IN_USE: begin
                    rows_cfg_next = cfg_data;
                end
                CFG_COLS_IN_USE: begin
                    cols_cfg_next = cfg_data;
                end
                default: begin
                    rows_cfg_next = rows_cfg_reg;
                end
            endcase
        end
    end

    // clamp sizes into the supported grid
    always_comb begin
        if (rows_cfg_reg < ROWS_MIN) begin
            rows_use = ROWS_MIN;
        end else if (rows_cfg_reg > CFG_W'(MAX_ROWS)) begin
            rows_use = CFG_W'(MAX_ROWS);
        end else begin
            rows_use = rows_cfg_reg;
        end
        if (cols_cfg_reg < COLS_MIN) begin
            cols_use = COLS_MIN;
        end else if (cols_cfg_reg > CFG_W'(MAX_COLS)) begin
            cols_use = CFG_W'(MAX_COLS);
        end else begin
            cols_use = cols_cfg_reg;
        end
    end

    // item accepted whenever the queue can take a pair of results
    assign s_ready = has_room;
    assign fire    = s_valid && s_ready;

    // row past the grid is the flush row; last column ends the row
    assign flush_row = (CFG_W'(row_reg) >= rows_use);
    assign col_plus  = CFG_W'(col_reg) + CFG_W'(1);
    assign row_end   = (col_plus >= cols_use);

    // new bottom cell: flush items and the flush row read as empty
    assign nb = !flush_row && !s_data.mode && s_data.cell_value;
    // rows above the grid are masked to empty
    assign nm = (row_reg != '0) ? mid_rd : 1'b0;
    assign nt = (row_reg[ROW_W-1:1] != '0) ? up_rd : 1'b0;

    // left of column 0 is empty
    assign window_eff = (col_reg == '0) ? 6'd0 : window_reg;

    always_comb begin
        row_next    = row_reg;
        col_next    = col_reg;
        window_next = window_reg;
        if (fire) begin
            window_next = {window_eff[2:0], nb, nm, nt};
            if (row_end) begin
                col_next = '0;
                row_next = flush_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            window_reg   <= '0;
        end else begin
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            window_reg   <= window_next;
        end
    end

    // line buffers are read one column ahead so the data is registered by the time
    // the item for that column arrives; while an item is written, the write column never equals the read column
    assign rd_addr = col_next;

    cagen_line_buf u_middle_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fire),
        .wr_addr (col_reg),
        .wr_data (nb),
        .rd_addr (rd_addr),
        .rd_data (mid_rd)
    );

    cagen_line_buf u_upper_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fire),
        .wr_addr (col_reg),
        .wr_data (nm),
        .rd_addr (rd_addr),
        .rd_data (up_rd)
    );

    always_comb begin
        nbhd.window    = window_eff;
        nbhd.nt        = nt;
        nbhd.nm        = nm;
        nbhd.nb        = nb;
        nbhd.row       = row_reg;
        nbhd.col       = col_reg;
        nbhd.row_end   = row_end;
        nbhd.flush_row = flush_row;
    end

    cagen_stencil u_stencil (
        .nbhd (nbhd),
        .pair (pair)
    );

    // pack the results in order: the interior cell before the row-end cell
    assign push_first  = fire && (pair.first_vld || pair.second_vld);
    assign push_second = fire && pair.first_vld && pair.second_vld;
    assign first_data  = pair.first_vld ? pair.first : pair.second;

    cagen_result_fifo u_result_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_first  (push_first),
        .push_second (push_second),
        .first_data  (first_data),
        .second_data (pair.second),
        .has_room    (has_room),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### design/cagen_line_buf.sv
`timescale 1ns / 1ps

module cagen_line_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [cagen_pkg::COL_W-1:0] wr_addr,
    input  logic                        wr_data,
    input  logic [cagen_pkg::COL_W-1:0] rd_addr,
    output logic                        rd_data
);
    import cagen_pkg::*;

    logic                line_mem [MAX_COLS];
    logic [MAX_COLS-1:0] vld_reg;
    logic [MAX_COLS-1:0] vld_next;
    logic                mem_rd_reg;
    logic                vld_rd_reg;

    // entries never written read as empty
    always_comb begin
        vld_next = vld_reg;
        if (wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end else begin
            vld_reg    <= vld_next;
            vld_rd_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        mem_rd_reg <= line_mem[rd_addr];
    end

    assign rd_data = mem_rd_reg & vld_rd_reg;

endmodule

### design/cagen_stencil.sv
`timescale 1ns / 1ps

module cagen_stencil (
    input  cagen_pkg::cagen_nbhd_t nbhd,
    output cagen_pkg::cagen_pair_t pair
);
    import cagen_pkg::*;

    logic             at, am, ab, bt, bm, bb;
    logic [CNT_W-1:0] d_first, o_first, d_second, o_second;
    logic [ROW_W-1:0] row_above;
    logic [COL_W-1:0] col_left;
    logic             has_row;

    function automatic logic rule_next(input logic center, input logic [CNT_W-1:0] d,
                                       input logic [CNT_W-1:0] o);
        logic res;
        res = 1'b0;
        if (d == FULL_CNT || o == FULL_CNT) begin
            res = 1'b1;
        end else if (d >= PAIR_CNT && o >= PAIR_CNT && center) begin
            res = 1'b1;
        end else if ((d >= PAIR_CNT && o == TRIPLE_CNT) || (d == TRIPLE_CNT && o >= PAIR_CNT)) begin
            res = 1'b1;
        end
        return res;
    endfunction

    assign at = nbhd.window[0];
    assign am = nbhd.window[1];
    assign ab = nbhd.window[2];
    assign bt = nbhd.window[3];
    assign bm = nbhd.window[4];
    assign bb = nbhd.window[5];

    // cell one row up, one column left: full 3x3 window
    assign d_first = CNT_W'(bt) + CNT_W'(bb) + CNT_W'(nbhd.nt) + CNT_W'(nbhd.nb);
    assign o_first = CNT_W'(at) + CNT_W'(ab) + CNT_W'(bm) + CNT_W'(nbhd.nm);
    // cell one row up at the last column: right side is empty
    assign d_second = CNT_W'(at) + CNT_W'(ab);
    assign o_second = CNT_W'(nbhd.nt) + CNT_W'(nbhd.nb) + CNT_W'(am);

    assign row_above = nbhd.row - ROW_W'(1);
    assign col_left  = nbhd.col - COL_W'(1);
    assign has_row   = (nbhd.row != '0);

    always_comb begin
        pair.first_vld          = has_row && (nbhd.col != '0);
        pair.first.next_value   = rule_next(am, d_first, o_first);
        pair.first.cell_row     = row_above[POS_W-1:0];
        pair.first.cell_col     = col_left[POS_W-1:0];
        pair.first.last_of_run  = !nbhd.row_end;
        pair.first.frame_done   = 1'b0;

        pair.second_vld         = has_row && nbhd.row_end;
        pair.second.next_value  = rule_next(nbhd.nm, d_second, o_second);
        pair.second.cell_row    = row_above[POS_W-1:0];
        pair.second.cell_col    = nbhd.col[POS_W-1:0];
        pair.second.last_of_run = 1'b1;
        pair.second.frame_done  = nbhd.flush_row;
    end

endmodule

### design/cagen_result_fifo.sv
`timescale 1ns / 1ps

module cagen_result_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_first,
    input  logic                  push_second,
    input  cagen_pkg::cagen_out_t first_data,
    input  cagen_pkg::cagen_out_t second_data,
    output logic                  has_room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cagen_pkg::cagen_out_t m_data
);
    import cagen_pkg::*;

    cagen_out_t        slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  wr_ptr_plus;
    logic              pop;

    assign pop         = m_valid && m_ready;
    assign wr_ptr_plus = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_first) + PTR_W'(push_second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + FILL_W'(push_first) + FILL_W'(push_second) - FILL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_first) begin
            slot_reg[wr_ptr_reg] <= first_data;
        end
        if (push_second) begin
            slot_reg[wr_ptr_plus] <= second_data;
        end
    end

    // room for a pair regardless of the output side
    assign has_room = (fill_reg <= FILL_W'(FIFO_DEPTH - 2));
    assign m_valid  = (fill_reg != '0);
    assign m_data   = slot_reg[rd_ptr_reg];

endmodule

### design/cagen_checker.sv
`timescale 1ns / 1ps

module cagen_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input cagen_pkg::cagen_out_t m_data
);
    import cagen_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing pending after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the end of a frame is always the last result of its item
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> m_data.last_of_run)
        else $error("frame end not marked last of run");

    // a result that is not last is followed at once by its right neighbor
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=>
            m_valid && m_data.last_of_run
            && (m_data.cell_row == $past(m_data.cell_row))
            && (m_data.cell_col == POS_W'($past(m_data.cell_col) + POS_W'(1))))
        else $error("row-end pair broken");

endmodule

bind cellular_automaton_generation_step cagen_checker u_cagen_checker (.*);

### tb/cellular_automaton_generation_step_tb.sv
`timescale 1ns / 1ps

module cellular_automaton_generation_step_tb;

    import cagen_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int RAND_ITEMS    = 600;
    // results are written into the result queue when the item that releases them is
    // accepted; the settle wait also covers a trailing first-column item
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 16;
    // slowest run: under 1000 items, each with the longest sender gap and two results
    // behind the longest stalls, plus the drains between phases; taken about five times over
    localparam int CYCLE_LIMIT   = 500_000;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_CFG,    // set both size registers while idle
        ROW_PRED,   // item checked against the predictor
        ROW_TYPED   // item with its results written out by hand
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        cagen_in_t        cell_in;
        logic [1:0]       n_typed;
        cagen_out_t       first;
        cagen_out_t       second;
    } stim_row_t;

    // directed part: fields are kind, rows, cols, {mode, cell}, typed count, results
    localparam stim_row_t STIM_TABLE [18] = '{
        // smallest grid: one row of two columns, then its flush row
        '{ROW_CFG,   7'd1, 7'd2, '{1'b0, 1'b0}, 2'd0, '0, '0},
        // first input row gives nothing, whatever the cells hold
        '{ROW_TYPED, 7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_TYPED, 7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        // flush row, first column: nothing out, and the filled bit reads as empty
        '{ROW_TYPED, 7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        // row end of the flush row: both cells, at most one neighbor each, so empty
        '{ROW_TYPED, 7'd0, 7'd0, '{1'b1, 1'b1}, 2'd2,
          '{1'b0, 6'd0, 6'd0, 1'b0, 1'b0}, '{1'b0, 6'd0, 6'd1, 1'b1, 1'b1}},
        // 3x3 grid, filled but for a mode-1 top middle and an empty bottom middle
        '{ROW_CFG,   7'd3, 7'd3, '{1'b0, 1'b0}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b1, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b0}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0},
        // flush row: mode 1 empty, mode 1 filled, mode 0 filled all read as empty
        '{ROW_PRED,  7'd0, 7'd0, '{1'b1, 1'b0}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b1, 1'b1}, 2'd0, '0, '0},
        '{ROW_PRED,  7'd0, 7'd0, '{1'b0, 1'b1}, 2'd0, '0, '0}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    cagen_in_t        s_data;
    logic             m_valid;
    logic             m_ready;
    cagen_out_t       m_data;
    logic             cfg_we;
    cagen_cfg_idx_t   cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // predictor state: the two rows above the input row, the two-column window
    // and the raster position, plus its own copy of the size registers
    bit [MAX_COLS-1:0] older_row;
    bit [MAX_COLS-1:0] newer_row;
    bit [5:0]          win;
    int                pred_row;
    int                pred_col;
    logic [CFG_W-1:0]  rows_reg = ROWS_RESET;
    logic [CFG_W-1:0]  cols_reg = COLS_RESET;

    cagen_out_t expected_cells [$];
    int         error_count = 0;
    bit         burst_mode;

    cellular_automaton_generation_step DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // size registers as the block uses them, clamped to the legal range
    function automatic int eff_rows();
        int r;
        r = rows_reg;
        if (r < ROWS_MIN) r = ROWS_MIN;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    function automatic int eff_cols();
        int c;
        c = cols_reg;
        if (c < COLS_MIN) c = COLS_MIN;
        if (c > MAX_COLS) c = MAX_COLS;
        return c;
    endfunction

    // the growth rule on diagonal count d and orthogonal count o
    function automatic bit next_state_of(input bit center, input int d, input int o);
        if (d == FULL_CNT || o == FULL_CNT) return 1'b1;
        if (d >= PAIR_CNT && o >= PAIR_CNT && center) return 1'b1;
        return (d >= PAIR_CNT && o == TRIPLE_CNT) || (d == TRIPLE_CNT && o >= PAIR_CNT);
    endfunction

    // one accepted item: returns how many cells it releases and what they are
    function automatic int advance_cell(input cagen_in_t it, output cagen_out_t first,
                                        output cagen_out_t second);
        int         nr;
        int         nc;
        int         n;
        int         d;
        int         o;
        bit         flush;
        bit         row_end;
        bit         nt;
        bit         nm;
        bit         nb;
        cagen_out_t res [2];
        nr = eff_rows();
        nc = eff_cols();
        flush = (pred_row >= nr);
        row_end = (pred_col + 1 >= nc);
        // position decides: anything in the flush row is empty, as is any mode-1 item
        nb = (it.mode || flush) ? 1'b0 : it.cell_value;
        nm = (pred_row >= 1) ? newer_row[pred_col] : 1'b0;
        nt = (pred_row >= 2) ? older_row[pred_col] : 1'b0;
        // left of column 0 is empty
        if (pred_col == 0) win = '0;
        res[0] = '0;
        res[1] = '0;
        n = 0;
        // cell one up and one left: window bits 0..2 are column c-1, 3..5 column c-2
        if (pred_row >= 1 && pred_col >= 1) begin
            d = win[3] + win[5] + nt + nb;
            o = win[0] + win[2] + win[4] + nm;
            res[n].next_value = next_state_of(win[1], d, o);
            res[n].cell_row = POS_W'(pred_row - 1);
            res[n].cell_col = POS_W'(pred_col - 1);
            res[n].last_of_run = !row_end;
            n++;
        end
        // row end also releases the cell right above, with empty space to its right
        if (pred_row >= 1 && row_end) begin
            d = win[0] + win[2];
            o = nt + nb + win[1];
            res[n].next_value = next_state_of(nm, d, o);
            res[n].cell_row = POS_W'(pred_row - 1);
            res[n].cell_col = POS_W'(pred_col);
            res[n].last_of_run = 1'b1;
            res[n].frame_done = flush;
            n++;
        end
        older_row[pred_col] = nm;
        newer_row[pred_col] = nb;
        win = {win[2:0], nb, nm, nt};
        if (row_end) begin
            pred_col = 0;
            pred_row = flush ? 0 : pred_row + 1;
        end else begin
            pred_col++;
        end
        first = res[0];
        second = res[1];
        return n;
    endfunction

    // mostly back to back, sometimes a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one item, hold it until taken, then record what it releases
    task automatic send_cell(input cagen_in_t it, input bit typed, input int n_typed,
                             input cagen_out_t t0, input cagen_out_t t1);
        int         gap;
        int         n;
        cagen_out_t p0;
        cagen_out_t p1;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = advance_cell(it, p0, p1);
        // hand-written rows override, the predictor still tracks the state
        if (typed) begin
            n = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) expected_cells.push_back(p0);
        if (n > 1) expected_cells.push_back(p1);
    endtask

    // sender holds off until every released cell is back and the block has settled
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write the size registers back to back, only while idle
    task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                            input bit wr_rows, input bit wr_cols);
        if (wr_rows) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_ROWS_IN_USE;
            cfg_data <= rows;
            @(posedge aclk);
            rows_reg = rows;
        end
        if (wr_cols) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_COLS_IN_USE;
            cfg_data <= cols;
            @(posedge aclk);
            cols_reg = cols;
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls on m_ready
    initial begin : ready_driver
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // every accepted result against the oldest expected cell
    initial begin : result_checker
        cagen_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                if (expected_cells.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected: got %p", $time, m_data);
                end else begin
                    want = expected_cells.pop_front();
                    if (m_data.next_value !== want.next_value
                            || m_data.cell_row !== want.cell_row
                            || m_data.cell_col !== want.cell_col
                            || m_data.last_of_run !== want.last_of_run
                            || m_data.frame_done !== want.frame_done) begin
                        error_count++;
                        $display("%0t: expected %p, got %p", $time, want, m_data);
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("cellular_automaton_generation_step: mismatch");
        $finish;
    end

    initial begin : stimulus
        int               rand_items;
        int               phase;
        int               sel;
        int               nr;
        int               nc;
        int               row_left;
        int               rem;
        int               count;
        int               density;
        bit               wr_r;
        bit               wr_c;
        bit               in_flush;
        logic [CFG_W-1:0] nr_v;
        logic [CFG_W-1:0] nc_v;
        cagen_in_t        it;

        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_data <= '0;
        aresetn <= 1'b0;
        burst_mode = 1'b0;
        pred_row = 0;
        pred_col = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (STIM_TABLE[i]) begin
            if (STIM_TABLE[i].kind == ROW_CFG) begin
                drain_results();
                set_grid(STIM_TABLE[i].rows, STIM_TABLE[i].cols, 1'b1, 1'b1);
            end else begin
                send_cell(STIM_TABLE[i].cell_in, STIM_TABLE[i].kind == ROW_TYPED,
                          STIM_TABLE[i].n_typed, STIM_TABLE[i].first, STIM_TABLE[i].second);
            end
        end

        // random phases: new sizes while idle, then the rest of the current frame or a cut-off part
        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            drain_results();
            wr_r = 1'b1;
            wr_c = 1'b1;
            case (phase)
                // rows above range, columns below: clamps to 64 rows by 2 columns
                0: begin nr_v = 7'd127; nc_v = 7'd0; end
                // one row of 64 columns; lands mid-frame, so the old row is past the grid
                1: begin nr_v = 7'd0;   nc_v = 7'd127; end
                // column position now past the last column
                2: begin nr_v = 7'd64;  nc_v = 7'd3; end
                3: begin nr_v = 7'd2;   nc_v = 7'd64; end
                default: begin
                    sel = $urandom_range(0, 99);
                    nr_v = CFG_W'($urandom_range(1, 6));
                    nc_v = CFG_W'($urandom_range(2, 8));
                    if (sel >= 65 && sel < 75) begin
                        // row count below or above range, narrow grid
                        nr_v = ($urandom_range(0, 2) == 0) ? 7'd0 : CFG_W'($urandom_range(65, 127));
                        nc_v = CFG_W'($urandom_range(2, 4));
                    end else if (sel >= 75 && sel < 85) begin
                        // column count below or above range, short grid
                        nr_v = CFG_W'($urandom_range(1, 2));
                        sel = $urandom_range(0, 2);
                        nc_v = (sel == 0) ? 7'd0 : (sel == 1) ? 7'd1
                                                            : CFG_W'($urandom_range(65, 127));
                    end else if (sel >= 85) begin
                        // only one register, the one keeping the frame small
                        wr_r = (eff_rows() > eff_cols());
                        wr_c = !wr_r;
                    end
                end
            endcase
            set_grid(nr_v, nc_v, wr_r, wr_c);
            burst_mode = ($urandom_range(0, 5) == 0);
            density = $urandom_range(0, 4);

            // items left to the end of the current frame
            nr = eff_rows();
            nc = eff_cols();
            row_left = (pred_col + 1 >= nc) ? 1 : nc - pred_col;
            rem = (pred_row >= nr) ? row_left : row_left + (nr - pred_row) * nc;
            if (phase == 0) count = 70;
            else if (phase == 1) count = 40;
            else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, rem);
            else count = rem;
            // keep the run near its item budget
            if (count > RAND_ITEMS - rand_items) count = RAND_ITEMS - rand_items;

            repeat (count) begin
                in_flush = (pred_row >= eff_rows());
                if (in_flush) begin
                    // flush row mostly mode 1, sometimes a stray mode-0 cell
                    it.mode = ($urandom_range(0, 4) != 0);
                    it.cell_value = 1'($urandom_range(0, 1));
                end else begin
                    it.mode = ($urandom_range(0, 9) == 0);
                    it.cell_value = ($urandom_range(0, 3) < density);
                end
                // occasional full hold-off mid-stream
                if ($urandom_range(0, 63) == 0) drain_results();
                send_cell(it, 1'b0, 0, '0, '0);
                rand_items++;
            end
            phase++;
        end

        drain_results();
        repeat (END_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("cellular_automaton_generation_step: match");
        end else begin
            $display("cellular_automaton_generation_step: mismatch");
        end
        $finish;
    end

endmodule

### files.f
design/cagen_pkg.sv
design/cagen_line_buf.sv
design/cagen_stencil.sv
design/cagen_result_fifo.sv
design/cellular_automaton_generation_step.sv
design/cagen_checker.sv
tb/cellular_automaton_generation_step_tb.sv
